[hdl/assert_macros.svh]
// Assertion macros used by the checker module.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define PWQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define PWQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define PWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[hdl/pwq_pkg.sv]
// Package for the priority wait queue: operation and status codes, state
// type, controller command and status structs. Depends on nothing.
`timescale 1ns / 1ps

package pwq_pkg;

  localparam int MAX_WAITERS_DEF   = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int ID_W    = 4;
  localparam int PRIO_IN_W = 8;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_SUSPEND    = 2'd0,
    OP_RESUME     = 2'd1,
    OP_RESUME_ALL = 2'd2
  } op_t;

  // Operation code three carries no meaning and is dropped without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    logic    insert;
    logic    pop;
    logic    first_pop;
    logic    emit;
    status_t status;
    logic    last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/pwq_ctrl.sv]
// Controller of the priority wait queue: decodes operations and sequences
// a resume-all drain. Depends on pwq_pkg.
`timescale 1ns / 1ps

module pwq_ctrl
  import pwq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.status    = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          case (in_operation)
            OP_SUSPEND: begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.insert = !stat.full;
              cmd.status = stat.full ? ST_FULL : ST_OK;
            end
            OP_RESUME: begin
              cmd.emit      = 1'b1;
              cmd.last      = 1'b1;
              cmd.pop       = !stat.empty;
              cmd.first_pop = 1'b1;
              cmd.status    = stat.empty ? ST_EMPTY : ST_OK;
            end
            OP_RESUME_ALL: begin
              cmd.emit      = 1'b1;
              cmd.pop       = !stat.empty;
              cmd.first_pop = 1'b1;
              cmd.status    = stat.empty ? ST_EMPTY : ST_OK;
              cmd.last      = stat.empty || stat.one;
              if (!stat.empty && !stat.one) begin
                state_nxt = S_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.pop  = 1'b1;
          cmd.last = stat.one;
          if (stat.one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/pwq_datapath.sv]
// Datapath of the priority wait queue: a sorted chain of waiter cells,
// the occupancy count, the release counter and the result register.
// Depends on pwq_pkg.
`timescale 1ns / 1ps

module pwq_datapath
  import pwq_pkg::*;
#(
  parameter int MAX_WAITERS   = MAX_WAITERS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ID_W-1:0]      in_waiter_id,
  input  logic [PRIO_IN_W-1:0] in_waiter_priority,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [ID_W-1:0]      out_released_id,
  output logic [COUNT_W-1:0]   out_released_count,
  output logic                 out_last
);

  localparam int OCC_W = $clog2(MAX_WAITERS + 1);

  logic [ID_W-1:0]          entry_id_r    [MAX_WAITERS];
  logic [ID_W-1:0]          entry_id_nxt  [MAX_WAITERS];
  logic [PRIORITY_BITS-1:0] entry_prio_r  [MAX_WAITERS];
  logic [PRIORITY_BITS-1:0] entry_prio_nxt[MAX_WAITERS];
  logic [MAX_WAITERS-1:0]   ahead;
  logic [PRIORITY_BITS-1:0] new_prio;

  logic [OCC_W-1:0]   occ_r;
  logic [OCC_W-1:0]   occ_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [ID_W-1:0]    out_id_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;

  assign new_prio = PRIORITY_BITS'(in_waiter_priority);

  always_comb begin
    for (int i = 0; i < MAX_WAITERS; i++) begin
      ahead[i] = (OCC_W'(i) < occ_r) && (entry_prio_r[i] <= new_prio);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAITERS; i++) begin
      entry_id_nxt[i]   = entry_id_r[i];
      entry_prio_nxt[i] = entry_prio_r[i];
      if (cmd.insert && !ahead[i]) begin
        if (i == 0) begin
          entry_id_nxt[i]   = in_waiter_id;
          entry_prio_nxt[i] = new_prio;
        end else if (ahead[i-1]) begin
          entry_id_nxt[i]   = in_waiter_id;
          entry_prio_nxt[i] = new_prio;
        end else begin
          entry_id_nxt[i]   = entry_id_r[i-1];
          entry_prio_nxt[i] = entry_prio_r[i-1];
        end
      end else if (cmd.pop && (i < MAX_WAITERS - 1)) begin
        entry_id_nxt[i]   = entry_id_r[i+1];
        entry_prio_nxt[i] = entry_prio_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WAITERS; i++) begin
      entry_id_r[i]   <= entry_id_nxt[i];
      entry_prio_r[i] <= entry_prio_nxt[i];
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.insert) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (cmd.pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
    count_nxt = count_r;
    if (cmd.pop) begin
      count_nxt = cmd.first_pop ? COUNT_W'(1) : count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      count_r <= count_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_id_r     <= cmd.pop ? entry_id_r[0] : '0;
      out_count_r  <= cmd.pop ? count_nxt : '0;
      out_last_r   <= cmd.last;
    end
  end

  assign stat.empty    = (occ_r == '0);
  assign stat.full     = (occ_r == OCC_W'(MAX_WAITERS));
  assign stat.one      = (occ_r == OCC_W'(1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_released_id    = out_id_r;
  assign out_released_count = out_count_r;
  assign out_last           = out_last_r;

endmodule

[hdl/priority_wait_queue_core.sv]
// Suspend and resume each give a single result, valid the cycle after the transfer.
// Resume-all gives one result per cycle unless stalled, one per waiter, set by the cell chain
// shifting one place per pop; a new item is taken once the drain's last result is registered.
// A stalled result holds the input off only while the result register stays full.
// Synchronous active-low reset empties the list; the cells themselves are not cleared.
`timescale 1ns / 1ps

module priority_wait_queue_core
  import pwq_pkg::*;
#(
  parameter int MAX_WAITERS   = MAX_WAITERS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic [ID_W-1:0]      in_waiter_id,
  input  logic [PRIO_IN_W-1:0] in_waiter_priority,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [ID_W-1:0]      out_released_id,
  output logic [COUNT_W-1:0]   out_released_count,
  output logic                 out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pwq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  pwq_datapath #(
    .MAX_WAITERS   (MAX_WAITERS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_waiter_id       (in_waiter_id),
    .in_waiter_priority (in_waiter_priority),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_released_id    (out_released_id),
    .out_released_count (out_released_count),
    .out_last           (out_last)
  );

endmodule

[hdl/pwq_checker.sv]
// Port-level checker for priority_wait_queue_core, attached by bind.
// Depends on pwq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwq_checker
  import pwq_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [1:0]           in_operation,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic [ID_W-1:0]      out_released_id,
  input logic [COUNT_W-1:0]   out_released_count,
  input logic                 out_last
);

  logic                              in_xfer;
  logic                              out_stall;
  logic                              op_used;
  logic                              out_error;
  logic                              out_is_empty;
  logic                              release_clear;
  logic [2+ID_W+COUNT_W:0]           held_fields;

  assign in_xfer       = in_valid && in_ready;
  assign out_stall     = out_valid && !out_ready;
  assign op_used       = (in_operation != OP_UNUSED);
  assign out_error     = out_valid && (out_status != ST_OK);
  assign out_is_empty  = out_valid && (out_status == ST_EMPTY);
  assign release_clear = (out_released_id == '0) && (out_released_count == '0);
  assign held_fields   = {out_status, out_released_id, out_released_count, out_last};

  `PWQ_ASSERT_NEXT(a_op_gives_result, clk, rst_n, in_xfer && op_used, out_valid)
  `PWQ_ASSERT_SAME(a_error_is_last, clk, rst_n, out_error, out_last)
  `PWQ_ASSERT_SAME(a_empty_clean, clk, rst_n, out_is_empty, release_clear)
  `PWQ_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_stall, out_valid && $stable(held_fields))
  `PWQ_ASSERT_ALWAYS(a_status_range, clk, rst_n, !out_valid || (out_status <= ST_FULL))

endmodule

bind priority_wait_queue_core pwq_checker u_pwq_checker (.*);

[tb/sv/priority_wait_queue_core_test.sv]
// Self-checking testbench for priority_wait_queue_core: a wait list sorted by priority,
// checked against a predictor of its own under random idling and a long result stall.
// Depends on pwq_pkg and the priority_wait_queue_core RTL.
`timescale 1ns / 1ps

module priority_wait_queue_core_test;
  import pwq_pkg::*;

  localparam int MAX_WAITERS    = MAX_WAITERS_DEF;
  localparam int PRIORITY_BITS  = PRIORITY_BITS_DEF;
  localparam int LONG_HOLD      = 48;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
    logic               last;
  } release_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_operation = 2'd0;
  logic [ID_W-1:0]      in_waiter_id = '0;
  logic [PRIO_IN_W-1:0] in_waiter_priority = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_status;
  logic [ID_W-1:0]      out_released_id;
  logic [COUNT_W-1:0]   out_released_count;
  logic                 out_last;

  release_t                 awaited_releases[$];
  logic [ID_W-1:0]          waiter_ids[MAX_WAITERS];
  logic [PRIORITY_BITS-1:0] waiter_prios[MAX_WAITERS];
  int                       waiting = 0;
  int                       mismatch_count = 0;
  bit                       calm = 1'b0;
  int                       hold_requests = 0;
  int                       holds_served = 0;
  int                       hold_left = 0;
  int                       stall_left = 0;

  priority_wait_queue_core #(
    .MAX_WAITERS  (MAX_WAITERS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_waiter_id      (in_waiter_id),
    .in_waiter_priority(in_waiter_priority),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_released_id   (out_released_id),
    .out_released_count(out_released_count),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  function automatic void await_release(status_t status, logic [ID_W-1:0] id,
                                        logic [COUNT_W-1:0] count, logic last);
    release_t r;
    r.status = status;
    r.id     = id;
    r.count  = count;
    r.last   = last;
    awaited_releases.push_back(r);
  endfunction

  function automatic logic [ID_W-1:0] pop_waiter();
    logic [ID_W-1:0] head;
    head = waiter_ids[0];
    for (int i = 1; i < waiting; i++) begin
      waiter_ids[i-1]   = waiter_ids[i];
      waiter_prios[i-1] = waiter_prios[i];
    end
    waiting--;
    return head;
  endfunction

  function automatic void predict_wait_list(logic [1:0] op, logic [ID_W-1:0] id,
                                            logic [PRIO_IN_W-1:0] prio_in);
    logic [PRIORITY_BITS-1:0] prio;
    logic [ID_W-1:0] rid;
    int pos;
    int k;
    prio = prio_in[PRIORITY_BITS-1:0];
    case (op)
      OP_SUSPEND: begin
        if (waiting >= MAX_WAITERS) begin
          await_release(ST_FULL, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < waiting && waiter_prios[pos] <= prio) pos++;
          for (int i = waiting; i > pos; i--) begin
            waiter_ids[i]   = waiter_ids[i-1];
            waiter_prios[i] = waiter_prios[i-1];
          end
          waiter_ids[pos]   = id;
          waiter_prios[pos] = prio;
          waiting++;
          await_release(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_RESUME: begin
        if (waiting == 0) begin
          await_release(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          await_release(ST_OK, pop_waiter(), COUNT_W'(1), 1'b1);
        end
      end
      OP_RESUME_ALL: begin
        if (waiting == 0) begin
          await_release(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          k = 0;
          while (waiting > 0) begin
            k++;
            rid = pop_waiter();
            await_release(ST_OK, rid, COUNT_W'(k), waiting == 0);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the item transfers.
  task automatic send_item(logic [1:0] op, logic [ID_W-1:0] id, logic [PRIO_IN_W-1:0] prio);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_waiter_id       <= id;
    in_waiter_priority <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_wait_list(op, id, prio);
  endtask

  function automatic logic [PRIO_IN_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0, 1: return PRIO_IN_W'($urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return PRIO_IN_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    release_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_releases.size() == 0) begin
        report_mismatch("result with none awaited", out_status, 8'd0);
      end else begin
        want = awaited_releases.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_released_id !== want.id) report_mismatch("released_id", out_released_id, want.id);
        if (out_released_count !== want.count) begin
          report_mismatch("released_count", out_released_count, want.count);
        end
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  task automatic test_empty_list();
    send_item(OP_RESUME, 4'hF, 8'hFF);
    send_item(OP_RESUME_ALL, 4'h0, 8'h00);
    send_item(OP_UNUSED, 4'hF, 8'hFF);
  endtask

  // Ties at several priorities check that equal waiters stay in arrival order.
  task automatic test_fill_and_drain();
    logic [PRIO_IN_W-1:0] prios[16] = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd7, 8'd7, 8'd1,
                                        8'd254, 8'd128, 8'd0, 8'd64, 8'd7, 8'd32, 8'd200, 8'd1};
    for (int i = 0; i < 16; i++) begin
      send_item(OP_SUSPEND, ID_W'(15 - i), prios[i]);
    end
    send_item(OP_SUSPEND, 4'h5, 8'h00);
    send_item(OP_UNUSED, 4'hA, 8'h55);
    send_item(OP_RESUME, 4'h0, 8'h00);
    send_item(OP_SUSPEND, 4'h9, 8'hFF);
    send_item(OP_RESUME_ALL, 4'hF, 8'hFF);
  endtask

  // The receiver holds off long enough for the result register to fill and stall the input.
  task automatic test_result_backpressure();
    hold_requests++;
    repeat (10) send_item(OP_SUSPEND, ID_W'($urandom), pick_priority());
    send_item(OP_RESUME, ID_W'($urandom), pick_priority());
    send_item(OP_RESUME_ALL, ID_W'($urandom), pick_priority());
  endtask

  task automatic test_random_traffic(int target);
    int sent;
    int pick;
    logic [1:0] op;
    sent = 0;
    while (sent < target) begin
      repeat ($urandom_range(1, 18)) begin
        send_item(OP_SUSPEND, ID_W'($urandom), pick_priority());
        sent++;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(OP_RESUME, ID_W'($urandom), pick_priority());
          sent++;
        end
      end else if (pick < 8) begin
        send_item(OP_RESUME_ALL, ID_W'($urandom), pick_priority());
        sent++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          op = 2'($urandom_range(0, 3));
          send_item(op, ID_W'($urandom), PRIO_IN_W'($urandom));
          if (op != OP_UNUSED) sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_and_drain();
    test_result_backpressure();
    test_random_traffic(210);
    calm = 1'b1;
    test_random_traffic(40);
    in_valid <= 1'b0;
    while (awaited_releases.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("status: fail");
    $finish;
  end

endmodule
